### hdl/wca_pkg.sv
// Shared constants, field layout and types for the weighted confusion accumulator.
// No dependencies; imported by every module of the block.
package wca_pkg;

    localparam int MAX_CLASSES = 8;
    localparam int IDX_W       = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int TREE_LVLS   = IDX_W;
    localparam int TREE_W      = 1 << TREE_LVLS;

    localparam int VAL_W   = 32;                 // Q16.16 scores, target, weight
    localparam int SUM_W   = 64;                 // Q48.16 sums
    localparam int CNT_W   = 4;                  // class_count register
    localparam int PC_W    = 3;                  // positive_class register
    localparam int TINT_W  = VAL_W - 16 + 1;     // integer part of |target|
    localparam int NUM_SUMS = 5;

    // s_axis_tdata: score_0..score_7, target_value, doc_weight
    localparam int TGT_LSB    = MAX_CLASSES * VAL_W;
    localparam int WGT_LSB    = TGT_LSB + VAL_W;
    localparam int S_TDATA_W  = ((WGT_LSB + VAL_W + 7) / 8) * 8;
    // m_axis_tdata: true_pos, target_pos, pred_pos, true_neg, target_neg
    localparam int M_TDATA_W  = NUM_SUMS * SUM_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLASS_COUNT    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POSITIVE_CLASS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_BORDER  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOGIT_BORDER   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_USE_WEIGHTS    = 3'd4;

    localparam logic [VAL_W-1:0] ONE_WEIGHT = 32'h0001_0000;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        logic [CNT_W-1:0] class_count;
        logic [PC_W-1:0]  positive_class;
        t_val             target_border;
        t_val             logit_border;
        logic             use_weights;
    } t_cfg;

    // per-document outcome handed from classification to accumulation
    typedef struct packed {
        logic             tpos;
        logic             ppos;
        logic             err;
        logic             last;
        logic [VAL_W-1:0] weight;
    } t_class_info;

endpackage

### hdl/wca_classify.sv
// Per-document classification: argmax tree or binary thresholds, target class,
// range check and effective weight. Combinational; depends on wca_pkg.
module wca_classify (
    input  wca_pkg::t_cfg                         i_cfg,
    input  logic [wca_pkg::S_TDATA_W-1:0]         i_data,
    input  logic                                  i_last,
    output wca_pkg::t_class_info                  o_info
);
    import wca_pkg::*;

    typedef struct packed {
        logic             vld;
        t_val             score;
        logic [IDX_W-1:0] idx;
    } t_cand;

    t_cand            tree [TREE_LVLS+1][TREE_W];
    logic [CNT_W-1:0] eff_count;
    logic             binary;
    t_val             score0;
    t_val             tv;
    logic             tv_neg;
    logic [VAL_W:0]   tv_mag;
    logic [TINT_W-1:0] tint;
    logic             gt_logit;
    logic             gt_target;
    logic             mc_tpos;
    logic             mc_err;
    logic             mc_ppos;

    always_comb begin
        if (i_cfg.class_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (i_cfg.class_count > CNT_W'(MAX_CLASSES)) begin
            eff_count = CNT_W'(MAX_CLASSES);
        end else begin
            eff_count = i_cfg.class_count;
        end
    end

    assign binary = (eff_count == CNT_W'(1));
    assign score0 = t_val'(i_data[VAL_W-1:0]);
    assign tv     = t_val'(i_data[TGT_LSB +: VAL_W]);

    // first-max search as a balanced tree; on a tie the lower index wins
    always_comb begin
        for (int k = 0; k < TREE_W; k++) begin
            if (k < MAX_CLASSES) begin
                tree[0][k].vld   = (eff_count > CNT_W'(k));
                tree[0][k].score = t_val'(i_data[k*VAL_W +: VAL_W]);
            end else begin
                tree[0][k].vld   = 1'b0;
                tree[0][k].score = '0;
            end
            tree[0][k].idx = IDX_W'(k);
        end
        for (int l = 1; l <= TREE_LVLS; l++) begin
            for (int k = 0; k < TREE_W; k++) begin
                if (k < (TREE_W >> l)) begin
                    if (tree[l-1][2*k+1].vld && (!tree[l-1][2*k].vld ||
                        (tree[l-1][2*k+1].score > tree[l-1][2*k].score))) begin
                        tree[l][k] = tree[l-1][2*k+1];
                    end else begin
                        tree[l][k] = tree[l-1][2*k];
                    end
                end else begin
                    tree[l][k] = '0;
                end
            end
        end
    end

    // truncation toward zero: class is -(|tv| >> 16) when negative
    assign tv_neg = tv[VAL_W-1];
    assign tv_mag = tv_neg ? ((VAL_W+1)'(0) - {tv[VAL_W-1], tv}) : {1'b0, tv};
    assign tint   = tv_mag[VAL_W:16];

    assign mc_tpos = (tint == TINT_W'(i_cfg.positive_class)) &&
                     (!tv_neg || (i_cfg.positive_class == '0));
    assign mc_err  = (tv_neg && (tint != '0)) || (tint >= TINT_W'(eff_count));
    assign mc_ppos = (PC_W'(tree[TREE_LVLS][0].idx) == i_cfg.positive_class);

    assign gt_logit  = (score0 > i_cfg.logit_border);
    assign gt_target = (tv > i_cfg.target_border);

    always_comb begin
        if (binary) begin
            o_info.tpos = (i_cfg.positive_class == PC_W'(1)) ? gt_target :
                          (i_cfg.positive_class == '0) && !gt_target;
            o_info.ppos = (i_cfg.positive_class == PC_W'(1)) ? gt_logit :
                          (i_cfg.positive_class == '0) && !gt_logit;
            o_info.err  = 1'b0;
        end else begin
            o_info.tpos = mc_tpos;
            o_info.ppos = mc_ppos;
            o_info.err  = mc_err;
        end
        o_info.last   = i_last;
        o_info.weight = i_cfg.use_weights ? i_data[WGT_LSB +: VAL_W] : ONE_WEIGHT;
    end

endmodule

### hdl/wca_accum.sv
// Saturating accumulators and result register with its handshake.
// Depends on wca_pkg.
module wca_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  wca_pkg::t_class_info          i_info,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [wca_pkg::M_TDATA_W-1:0] o_sums,
    output logic                          o_err
);
    import wca_pkg::*;

    logic [SUM_W-1:0] r_tp, r_tpos, r_ppos, r_tn, r_tneg;
    logic [SUM_W-1:0] n_tp, n_tpos, n_ppos, n_tn, n_tneg;
    logic             r_err_seen, n_err_seen;
    logic             r_out_valid;
    logic [M_TDATA_W-1:0] r_sums;
    logic             r_err;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    always_comb begin
        n_tp       = (i_info.tpos && i_info.ppos) ? sat_add(r_tp, i_info.weight) : r_tp;
        n_tpos     = i_info.tpos ? sat_add(r_tpos, i_info.weight) : r_tpos;
        n_ppos     = i_info.ppos ? sat_add(r_ppos, i_info.weight) : r_ppos;
        n_tn       = (!i_info.tpos && !i_info.ppos) ? sat_add(r_tn, i_info.weight) : r_tn;
        n_tneg     = !i_info.tpos ? sat_add(r_tneg, i_info.weight) : r_tneg;
        n_err_seen = r_err_seen || i_info.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp       <= '0;
            r_tpos     <= '0;
            r_ppos     <= '0;
            r_tn       <= '0;
            r_tneg     <= '0;
            r_err_seen <= 1'b0;
        end else if (i_adv) begin
            if (i_info.last) begin
                r_tp       <= '0;
                r_tpos     <= '0;
                r_ppos     <= '0;
                r_tn       <= '0;
                r_tneg     <= '0;
                r_err_seen <= 1'b0;
            end else begin
                r_tp       <= n_tp;
                r_tpos     <= n_tpos;
                r_ppos     <= n_ppos;
                r_tn       <= n_tn;
                r_tneg     <= n_tneg;
                r_err_seen <= n_err_seen;
            end
        end
    end

    // caller only advances a last item when this register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv && i_info.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_info.last) begin
            r_sums <= {n_tneg, n_tn, n_ppos, n_tpos, n_tp};
            r_err  <= n_err_seen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sums      = r_sums;
    assign o_err       = r_err;

endmodule

### hdl/weighted_confusion_accumulator.sv
// Weighted one-vs-rest confusion accumulator, top level.
// Holds configuration, input and classification registers; uses wca_pkg,
// wca_classify and wca_accum.
//
// Usage:
//   s_axis carries one document per transaction: eight Q16.16 scores, the
//   target and the weight in tdata, the last-of-range mark in tlast.
//   m_axis carries one result per range, emitted for the document with
//   tlast set: five Q48.16 sums in tdata, the range error flag in tuser.
//   The sums and the flag clear once a result has been taken into the
//   output register, so the next document starts a new range.
//   A result reaches m_axis through the input register, the classification
//   register and the output register. Throughput: one document per cycle
//   while no last document waits for the output register, set by the
//   combinational argmax tree and 64-bit saturating adds.
//   Stalls: documents that are not last keep flowing while a result waits
//   on m_axis; a last document waits in the classification register until
//   the output register is free, and backpressure then reaches s_axis.
//   Reset (synchronous, active low) clears the pipeline, the sums and the
//   flag, and restores the register defaults. Configuration writes belong
//   to idle periods only.
module weighted_confusion_accumulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wca_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [wca_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // score_0..score_7, target_value, doc_weight
    input  logic [wca_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // true_pos_sum, target_pos_sum, pred_pos_sum, true_neg_sum, target_neg_sum
    output logic [wca_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // target_range_error
    output logic                              m_axis_tuser
);
    import wca_pkg::*;

    t_cfg                 r_cfg;
    logic                 r_in_valid;
    logic [S_TDATA_W-1:0] r_in_data;
    logic                 r_in_last;
    logic                 r_cls_valid;
    t_class_info          r_cls_info;
    t_class_info          cls_info;
    logic                 out_valid;
    logic                 out_free;
    logic                 s2_adv;
    logic                 s2_free;
    logic                 s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.class_count    <= CNT_W'(1);
            r_cfg.positive_class <= PC_W'(1);
            r_cfg.target_border  <= t_val'(32'sd32768);
            r_cfg.logit_border   <= '0;
            r_cfg.use_weights    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CLASS_COUNT:    r_cfg.class_count    <= i_cfg_data[CNT_W-1:0];
                CFG_POSITIVE_CLASS: r_cfg.positive_class <= i_cfg_data[PC_W-1:0];
                CFG_TARGET_BORDER:  r_cfg.target_border  <= t_val'(i_cfg_data);
                CFG_LOGIT_BORDER:   r_cfg.logit_border   <= t_val'(i_cfg_data);
                CFG_USE_WEIGHTS:    r_cfg.use_weights    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // only a last document needs the output register
    assign out_free = !out_valid || m_axis_tready;
    assign s2_adv   = r_cls_valid && (!r_cls_info.last || out_free);
    assign s2_free  = !r_cls_valid || s2_adv;
    assign s1_free  = !r_in_valid || s2_free;
    assign s_axis_tready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_cls_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (s2_free) begin
                r_cls_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (s2_free && r_in_valid) begin
            r_cls_info <= cls_info;
        end
    end

    wca_classify u_classify (
        .i_cfg  (r_cfg),
        .i_data (r_in_data),
        .i_last (r_in_last),
        .o_info (cls_info)
    );

    wca_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (s2_adv),
        .i_info      (r_cls_info),
        .i_out_ready (m_axis_tready),
        .o_out_valid (out_valid),
        .o_sums      (m_axis_tdata),
        .o_err       (m_axis_tuser)
    );

    assign m_axis_tvalid = out_valid;

endmodule

### hdl/wca_checker.sv
// Port-level checks for the weighted confusion accumulator, bound to the top.
// Depends on wca_pkg and weighted_confusion_accumulator.
module wca_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [wca_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);
    import wca_pkg::*;

    // no stale result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an empty output register never backs up the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output register empty");

    // a stalled result holds
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // an offered document is refused only while a result sits stalled
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("ready dropped without a stalled result");

endmodule

bind weighted_confusion_accumulator wca_checker u_wca_checker (.*);
